@@ hdl/cot_pkg.sv @@
// Shared constants for the capsule overlap test unit.
package cot_pkg;

  // Result and register widths fixed by the interface
  localparam int unsigned DIST_W    = 53;
  localparam int unsigned LIMIT_W   = 16;
  localparam int unsigned APB_DW    = 32;
  localparam int unsigned ADDR_W    = 5;
  localparam int unsigned REG_IDX_W = 3;

  // Point-to-segment evaluations per query
  localparam int unsigned NUM_LANES = 6;

  // Register indexes (byte address = 4 * index)
  localparam logic [REG_IDX_W-1:0] REG_START_X = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_START_Y = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_START_Z = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_END_X   = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_END_Y   = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_END_Z   = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_RADIUS  = 3'd6;
  localparam logic [REG_IDX_W-1:0] REG_LIMIT   = 3'd7;

  // Reset values
  localparam logic [LIMIT_W-1:0] LIMIT_RESET  = 16'd1;
  localparam int unsigned        RADIUS_RESET = 12800;

endpackage

@@ hdl/cot_query_if.sv @@
// Query channel: valid/ready handshake carrying one query shape.
interface cot_query_if #(
  parameter int unsigned COORD_BITS = 24
);
  logic                         valid;
  logic                         ready;
  logic                         mode;
  logic signed [COORD_BITS-1:0] other_start_x;
  logic signed [COORD_BITS-1:0] other_start_y;
  logic signed [COORD_BITS-1:0] other_start_z;
  logic signed [COORD_BITS-1:0] other_end_x;
  logic signed [COORD_BITS-1:0] other_end_y;
  logic signed [COORD_BITS-1:0] other_end_z;
  logic        [COORD_BITS-2:0] other_radius;

  modport source (
    output valid, mode, other_start_x, other_start_y, other_start_z,
    output other_end_x, other_end_y, other_end_z, other_radius,
    input  ready
  );
  modport sink (
    input  valid, mode, other_start_x, other_start_y, other_start_z,
    input  other_end_x, other_end_y, other_end_z, other_radius,
    output ready
  );
endinterface

@@ hdl/cot_result_if.sv @@
// Result channel: valid/ready handshake carrying overlap flag and distance.
interface cot_result_if;
  logic                        valid;
  logic                        ready;
  logic                        overlap;
  logic [cot_pkg::DIST_W-1:0]  distance_sq;

  modport source (output valid, overlap, distance_sq, input ready);
  modport sink (input valid, overlap, distance_sq, output ready);
endinterface

@@ hdl/capsule_overlap_test_unit.sv @@
// Capsule overlap test unit: pipelined capsule vs sphere/capsule distance test.
//
//  channel   dir  handshake            transaction
//  query_i   in   valid/ready          mode, other start/end, other radius
//  result_o  out  valid/ready          overlap, distance_sq
//  apb       in   psel/penable/pready  one register write or read
//
// One query per cycle sustained while the result is taken; the divider
// yields one bit of t per stage.
// Six point-to-segment lanes run side by side from the differences stage through the per-lane distance sum.
// Reset clears the stage valid bits and loads the register reset values.
// Each stage holds its transaction only while it and every stage after it are full and the result
// is not taken; empty stages are filled even while the result waits, so bubbles close up.
module capsule_overlap_test_unit #(
  parameter int unsigned COORD_BITS  = 24,
  parameter int unsigned T_FRAC_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  cot_query_if.sink                     query_i,
  cot_result_if.source                  result_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [cot_pkg::ADDR_W-1:0]    paddr,
  input  logic [cot_pkg::APB_DW-1:0]    pwdata,
  output logic [cot_pkg::APB_DW-1:0]    prdata,
  output logic                          pready
);

  localparam int unsigned C   = COORD_BITS;
  localparam int unsigned T   = T_FRAC_BITS;
  localparam int unsigned NL  = cot_pkg::NUM_LANES;
  localparam int unsigned SW  = C + 1;          // seg / ps
  localparam int unsigned PW  = 2 * SW;         // axis products
  localparam int unsigned LW  = 2 * C + 4;      // len2, dot, remainder
  localparam int unsigned TW  = T + 1;          // t in [0, 1]
  localparam int unsigned OW  = SW + TW + 1;    // seg * t
  localparam int unsigned DW  = SW + 1;         // closest point offset
  localparam int unsigned QW  = 2 * DW + 2;     // distance squared
  localparam int unsigned RW  = 2 * C;          // radius sum squared
  localparam int unsigned XW  = (QW > cot_pkg::DIST_W) ? QW : cot_pkg::DIST_W + 1;
  localparam logic [TW-1:0] T_ONE = {1'b1, {T{1'b0}}};
  localparam logic [XW-1:0] DIST_MAX = XW'({cot_pkg::DIST_W{1'b1}});

  // Lane map: 0..2 test my points against the query segment,
  // 3..5 test query points against my segment. Lane 3 alone serves mode 0.
  localparam int unsigned LANE_OS = 3;

  // Stage numbers
  localparam int unsigned ST_IN  = 0;
  localparam int unsigned ST_DIF = 1;
  localparam int unsigned ST_MUL = 2;
  localparam int unsigned ST_SUM = 3;
  localparam int unsigned ST_INI = 4;
  localparam int unsigned ST_OFF = T + 5;
  localparam int unsigned ST_DST = T + 6;
  localparam int unsigned ST_SQ  = T + 7;
  localparam int unsigned ST_ADD = T + 8;
  localparam int unsigned ST_MN1 = T + 9;
  localparam int unsigned ST_MN2 = T + 10;
  localparam int unsigned ST_OUT = T + 11;
  localparam int unsigned NST    = T + 12;

  // ---------------------------------------------------------------------
  // Configuration registers
  logic signed [C-1:0]                 cfg_s_q [3];
  logic signed [C-1:0]                 cfg_e_q [3];
  logic        [C-2:0]                 cfg_rad_q;
  logic        [cot_pkg::LIMIT_W-1:0]  cfg_limit_q;
  logic        [cot_pkg::REG_IDX_W-1:0] reg_idx;

  assign reg_idx = paddr[cot_pkg::ADDR_W-1:2];
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int a = 0; a < 3; a++) begin
        cfg_s_q[a] <= '0;
        cfg_e_q[a] <= '0;
      end
      cfg_rad_q   <= (C-1)'(cot_pkg::RADIUS_RESET);
      cfg_limit_q <= cot_pkg::LIMIT_RESET;
    end else if (psel && penable && pwrite) begin
      unique case (reg_idx)
        cot_pkg::REG_START_X: cfg_s_q[0] <= pwdata[C-1:0];
        cot_pkg::REG_START_Y: cfg_s_q[1] <= pwdata[C-1:0];
        cot_pkg::REG_START_Z: cfg_s_q[2] <= pwdata[C-1:0];
        cot_pkg::REG_END_X:   cfg_e_q[0] <= pwdata[C-1:0];
        cot_pkg::REG_END_Y:   cfg_e_q[1] <= pwdata[C-1:0];
        cot_pkg::REG_END_Z:   cfg_e_q[2] <= pwdata[C-1:0];
        cot_pkg::REG_RADIUS:  cfg_rad_q  <= pwdata[C-2:0];
        cot_pkg::REG_LIMIT:   cfg_limit_q <= pwdata[cot_pkg::LIMIT_W-1:0];
      endcase
    end
  end

  // Register readback
  always_comb begin
    unique case (reg_idx)
      cot_pkg::REG_START_X: prdata = cot_pkg::APB_DW'(cfg_s_q[0]);
      cot_pkg::REG_START_Y: prdata = cot_pkg::APB_DW'(cfg_s_q[1]);
      cot_pkg::REG_START_Z: prdata = cot_pkg::APB_DW'(cfg_s_q[2]);
      cot_pkg::REG_END_X:   prdata = cot_pkg::APB_DW'(cfg_e_q[0]);
      cot_pkg::REG_END_Y:   prdata = cot_pkg::APB_DW'(cfg_e_q[1]);
      cot_pkg::REG_END_Z:   prdata = cot_pkg::APB_DW'(cfg_e_q[2]);
      cot_pkg::REG_RADIUS:  prdata = cot_pkg::APB_DW'(cfg_rad_q);
      cot_pkg::REG_LIMIT:   prdata = cot_pkg::APB_DW'(cfg_limit_q);
    endcase
  end

  // ---------------------------------------------------------------------
  // Pipeline flow control: a stage loads when any stage from it onward is
  // empty or the result is being taken.
  logic [NST-1:0] v_q;
  logic [NST:0]   go;

  always_comb begin
    go[NST] = result_o.ready;
    for (int k = 0; k < NST; k++) begin
      go[k] = result_o.ready || (((~v_q) >> k) != '0);
    end
  end

  assign query_i.ready = go[ST_IN];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (go[0]) v_q[0] <= query_i.valid;
      for (int k = 1; k < NST; k++) begin
        if (go[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  // ---------------------------------------------------------------------
  // Input stage
  logic                in_mode_q;
  logic signed [C-1:0] in_os_q [3];
  logic signed [C-1:0] in_oe_q [3];
  logic        [C-2:0] in_orad_q;

  always_ff @(posedge clk_i) begin
    if (go[ST_IN]) begin
      in_mode_q  <= query_i.mode;
      in_os_q[0] <= query_i.other_start_x;
      in_os_q[1] <= query_i.other_start_y;
      in_os_q[2] <= query_i.other_start_z;
      in_oe_q[0] <= query_i.other_end_x;
      in_oe_q[1] <= query_i.other_end_y;
      in_oe_q[2] <= query_i.other_end_z;
      in_orad_q  <= query_i.other_radius;
    end
  end

  // ---------------------------------------------------------------------
  // Differences: midpoints, lane setup, seg = e - s, ps = p - s
  logic signed [SW-1:0] dif_seg_d [NL][3];
  logic signed [SW-1:0] dif_ps_d  [NL][3];
  logic        [C-1:0]  dif_rsum_d;
  logic signed [SW-1:0] dif_seg_q [NL][3];
  logic signed [SW-1:0] dif_ps_q  [NL][3];
  logic        [C-1:0]  dif_rsum_q;
  logic                 dif_mode_q;

  always_comb begin
    logic [C:0]          msum;
    logic [C:0]          osum;
    logic signed [C-1:0] mm;
    logic signed [C-1:0] om;
    logic signed [C-1:0] lp [NL];
    logic signed [C-1:0] ls [NL];
    logic signed [C-1:0] le [NL];
    for (int a = 0; a < 3; a++) begin
      // floor((a + b) / 2)
      msum = {cfg_s_q[a][C-1], cfg_s_q[a]} + {cfg_e_q[a][C-1], cfg_e_q[a]};
      osum = {in_os_q[a][C-1], in_os_q[a]} + {in_oe_q[a][C-1], in_oe_q[a]};
      mm = msum[C:1];
      om = osum[C:1];
      lp[0] = cfg_s_q[a];
      lp[1] = cfg_e_q[a];
      lp[2] = mm;
      lp[3] = in_os_q[a];
      lp[4] = in_oe_q[a];
      lp[5] = om;
      for (int l = 0; l < NL; l++) begin
        ls[l] = (l < 3) ? in_os_q[a] : cfg_s_q[a];
        le[l] = (l < 3) ? in_oe_q[a] : cfg_e_q[a];
        dif_seg_d[l][a] = SW'(le[l]) - SW'(ls[l]);
        dif_ps_d[l][a]  = SW'(lp[l]) - SW'(ls[l]);
      end
    end
    dif_rsum_d = C'(cfg_rad_q) + C'(in_orad_q);
  end

  always_ff @(posedge clk_i) begin
    if (go[ST_DIF]) begin
      dif_seg_q  <= dif_seg_d;
      dif_ps_q   <= dif_ps_d;
      dif_rsum_q <= dif_rsum_d;
      dif_mode_q <= in_mode_q;
    end
  end

  // ---------------------------------------------------------------------
  // Products: seg^2 and ps*seg per axis, radius sum squared
  logic signed [PW-1:0] mul_sq_d [NL][3];
  logic signed [PW-1:0] mul_dp_d [NL][3];
  logic signed [PW-1:0] mul_sq_q [NL][3];
  logic signed [PW-1:0] mul_dp_q [NL][3];
  logic signed [SW-1:0] mul_seg_q [NL][3];
  logic signed [SW-1:0] mul_ps_q  [NL][3];
  logic        [RW-1:0] mul_rs2_q;
  logic                 mul_mode_q;

  always_comb begin
    for (int l = 0; l < NL; l++) begin
      for (int a = 0; a < 3; a++) begin
        mul_sq_d[l][a] = dif_seg_q[l][a] * dif_seg_q[l][a];
        mul_dp_d[l][a] = dif_ps_q[l][a] * dif_seg_q[l][a];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (go[ST_MUL]) begin
      mul_sq_q   <= mul_sq_d;
      mul_dp_q   <= mul_dp_d;
      mul_seg_q  <= dif_seg_q;
      mul_ps_q   <= dif_ps_q;
      mul_rs2_q  <= RW'(dif_rsum_q) * RW'(dif_rsum_q);
      mul_mode_q <= dif_mode_q;
    end
  end

  // ---------------------------------------------------------------------
  // Sums: len2 = |seg|^2, dot = ps . seg
  logic signed [LW-1:0] sum_len_d [NL];
  logic signed [LW-1:0] sum_dot_d [NL];
  logic signed [LW-1:0] sum_len_q [NL];
  logic signed [LW-1:0] sum_dot_q [NL];
  logic signed [SW-1:0] sum_seg_q [NL][3];
  logic signed [SW-1:0] sum_ps_q  [NL][3];
  logic        [RW-1:0] sum_rs2_q;
  logic                 sum_mode_q;

  always_comb begin
    for (int l = 0; l < NL; l++) begin
      sum_len_d[l] = LW'(mul_sq_q[l][0]) + LW'(mul_sq_q[l][1]) + LW'(mul_sq_q[l][2]);
      sum_dot_d[l] = LW'(mul_dp_q[l][0]) + LW'(mul_dp_q[l][1]) + LW'(mul_dp_q[l][2]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (go[ST_SUM]) begin
      sum_len_q  <= sum_len_d;
      sum_dot_q  <= sum_dot_d;
      sum_seg_q  <= mul_seg_q;
      sum_ps_q   <= mul_ps_q;
      sum_rs2_q  <= mul_rs2_q;
      sum_mode_q <= mul_mode_q;
    end
  end

  // ---------------------------------------------------------------------
  // Divider: index 0 is the setup stage, 1..T each resolve one bit of t
  logic        [LW-1:0] dv_r_q   [T+1][NL];
  logic        [TW-1:0] dv_t_q   [T+1][NL];
  logic                 dv_run_q [T+1][NL];
  logic        [LW-1:0] dv_len_q [T+1][NL];
  logic signed [SW-1:0] dv_seg_q [T+1][NL][3];
  logic signed [SW-1:0] dv_ps_q  [T+1][NL][3];
  logic        [RW-1:0] dv_rs2_q [T+1];
  logic                 dv_mode_q[T+1];

  logic        [LW-1:0] ini_r_d   [NL];
  logic        [TW-1:0] ini_t_d   [NL];
  logic                 ini_run_d [NL];
  logic        [LW-1:0] dv_rn     [T][NL];
  logic        [TW-1:0] dv_tn     [T][NL];

  // Setup: short segment or projection before start gives t = 0,
  // projection past the end gives t = 1, otherwise divide dot / len2
  always_comb begin
    logic degen;
    for (int l = 0; l < NL; l++) begin
      degen = $unsigned(sum_len_q[l]) < LW'(cfg_limit_q);
      ini_r_d[l] = $unsigned(sum_dot_q[l]);
      if (degen || sum_dot_q[l] <= 0) begin
        ini_t_d[l]   = '0;
        ini_run_d[l] = 1'b0;
      end else if (sum_dot_q[l] >= sum_len_q[l]) begin
        ini_t_d[l]   = T_ONE;
        ini_run_d[l] = 1'b0;
      end else begin
        ini_t_d[l]   = '0;
        ini_run_d[l] = 1'b1;
      end
    end
  end

  // Restoring division steps
  always_comb begin
    logic [LW-1:0] r2;
    logic          ge;
    for (int j = 0; j < T; j++) begin
      for (int l = 0; l < NL; l++) begin
        r2 = {dv_r_q[j][l][LW-2:0], 1'b0};
        ge = dv_run_q[j][l] && (r2 >= dv_len_q[j][l]);
        if (!dv_run_q[j][l]) begin
          dv_rn[j][l] = dv_r_q[j][l];
          dv_tn[j][l] = dv_t_q[j][l];
        end else begin
          dv_rn[j][l] = ge ? (r2 - dv_len_q[j][l]) : r2;
          dv_tn[j][l] = {dv_t_q[j][l][TW-2:0], ge};
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (go[ST_INI]) begin
      for (int l = 0; l < NL; l++) begin
        dv_r_q[0][l]   <= ini_r_d[l];
        dv_t_q[0][l]   <= ini_t_d[l];
        dv_run_q[0][l] <= ini_run_d[l];
        dv_len_q[0][l] <= $unsigned(sum_len_q[l]);
      end
      dv_seg_q[0]  <= sum_seg_q;
      dv_ps_q[0]   <= sum_ps_q;
      dv_rs2_q[0]  <= sum_rs2_q;
      dv_mode_q[0] <= sum_mode_q;
    end
    for (int j = 1; j <= T; j++) begin
      if (go[ST_INI + j]) begin
        dv_r_q[j]    <= dv_rn[j-1];
        dv_t_q[j]    <= dv_tn[j-1];
        dv_run_q[j]  <= dv_run_q[j-1];
        dv_len_q[j]  <= dv_len_q[j-1];
        dv_seg_q[j]  <= dv_seg_q[j-1];
        dv_ps_q[j]   <= dv_ps_q[j-1];
        dv_rs2_q[j]  <= dv_rs2_q[j-1];
        dv_mode_q[j] <= dv_mode_q[j-1];
      end
    end
  end

  // ---------------------------------------------------------------------
  // Offset product: seg * t
  logic signed [OW-1:0] off_prod_d [NL][3];
  logic signed [OW-1:0] off_prod_q [NL][3];
  logic signed [SW-1:0] off_ps_q   [NL][3];
  logic        [RW-1:0] off_rs2_q;
  logic                 off_mode_q;

  always_comb begin
    for (int l = 0; l < NL; l++) begin
      for (int a = 0; a < 3; a++) begin
        off_prod_d[l][a] = dv_seg_q[T][l][a] * $signed({1'b0, dv_t_q[T][l]});
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (go[ST_OFF]) begin
      off_prod_q <= off_prod_d;
      off_ps_q   <= dv_ps_q[T];
      off_rs2_q  <= dv_rs2_q[T];
      off_mode_q <= dv_mode_q[T];
    end
  end

  // ---------------------------------------------------------------------
  // Separation: d = ps - floor(seg * t)
  logic signed [DW-1:0] dst_d_d [NL][3];
  logic signed [DW-1:0] dst_d_q [NL][3];
  logic        [RW-1:0] dst_rs2_q;
  logic                 dst_mode_q;

  always_comb begin
    for (int l = 0; l < NL; l++) begin
      for (int a = 0; a < 3; a++) begin
        dst_d_d[l][a] = DW'(off_ps_q[l][a]) - DW'(off_prod_q[l][a] >>> T);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (go[ST_DST]) begin
      dst_d_q    <= dst_d_d;
      dst_rs2_q  <= off_rs2_q;
      dst_mode_q <= off_mode_q;
    end
  end

  // ---------------------------------------------------------------------
  // Squares of the separation
  logic signed [2*DW-1:0] sq_d   [NL][3];
  logic signed [2*DW-1:0] sq_q   [NL][3];
  logic        [RW-1:0]   sq_rs2_q;
  logic                   sq_mode_q;

  always_comb begin
    for (int l = 0; l < NL; l++) begin
      for (int a = 0; a < 3; a++) begin
        sq_d[l][a] = dst_d_q[l][a] * dst_d_q[l][a];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (go[ST_SQ]) begin
      sq_q      <= sq_d;
      sq_rs2_q  <= dst_rs2_q;
      sq_mode_q <= dst_mode_q;
    end
  end

  // ---------------------------------------------------------------------
  // Per-lane distance squared
  logic [QW-1:0] add_dist_d [NL];
  logic [QW-1:0] add_dist_q [NL];
  logic [RW-1:0] add_rs2_q;
  logic          add_mode_q;

  always_comb begin
    logic signed [QW-1:0] s;
    for (int l = 0; l < NL; l++) begin
      s = QW'(sq_q[l][0]) + QW'(sq_q[l][1]) + QW'(sq_q[l][2]);
      add_dist_d[l] = $unsigned(s);
    end
  end

  always_ff @(posedge clk_i) begin
    if (go[ST_ADD]) begin
      add_dist_q <= add_dist_d;
      add_rs2_q  <= sq_rs2_q;
      add_mode_q <= sq_mode_q;
    end
  end

  // ---------------------------------------------------------------------
  // Minimum, first level: three pairs, lane 3 kept for mode 0
  logic [QW-1:0] mn1_min_q [3];
  logic [QW-1:0] mn1_os_q;
  logic [RW-1:0] mn1_rs2_q;
  logic          mn1_mode_q;

  always_ff @(posedge clk_i) begin
    if (go[ST_MN1]) begin
      mn1_min_q[0] <= (add_dist_q[0] <= add_dist_q[1]) ? add_dist_q[0] : add_dist_q[1];
      mn1_min_q[1] <= (add_dist_q[2] <= add_dist_q[4]) ? add_dist_q[2] : add_dist_q[4];
      mn1_min_q[2] <= (add_dist_q[5] <= add_dist_q[LANE_OS]) ?
                      add_dist_q[5] : add_dist_q[LANE_OS];
      mn1_os_q     <= add_dist_q[LANE_OS];
      mn1_rs2_q    <= add_rs2_q;
      mn1_mode_q   <= add_mode_q;
    end
  end

  // Minimum, second level, and mode select
  logic [QW-1:0] mn2_dist_d;
  logic [QW-1:0] mn2_dist_q;
  logic [RW-1:0] mn2_rs2_q;

  always_comb begin
    logic [QW-1:0] m01;
    m01 = (mn1_min_q[0] <= mn1_min_q[1]) ? mn1_min_q[0] : mn1_min_q[1];
    if (mn1_mode_q) begin
      mn2_dist_d = (m01 <= mn1_min_q[2]) ? m01 : mn1_min_q[2];
    end else begin
      mn2_dist_d = mn1_os_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (go[ST_MN2]) begin
      mn2_dist_q <= mn2_dist_d;
      mn2_rs2_q  <= mn1_rs2_q;
    end
  end

  // ---------------------------------------------------------------------
  // Output register: overlap compare and saturation
  logic [XW-1:0]              out_wide;
  logic                       out_overlap_q;
  logic [cot_pkg::DIST_W-1:0] out_dist_q;

  assign out_wide = XW'(mn2_dist_q);

  always_ff @(posedge clk_i) begin
    if (go[ST_OUT]) begin
      out_overlap_q <= mn2_dist_q <= QW'(mn2_rs2_q);
      out_dist_q    <= (out_wide > DIST_MAX) ? DIST_MAX[cot_pkg::DIST_W-1:0]
                                             : out_wide[cot_pkg::DIST_W-1:0];
    end
  end

  assign result_o.valid       = v_q[ST_OUT];
  assign result_o.overlap     = out_overlap_q;
  assign result_o.distance_sq = out_dist_q;

`ifndef SYNTHESIS
  // Lane 3 divider remainder is below len2 after the last step
  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[ST_INI + T] && dv_run_q[T][LANE_OS] |->
      dv_r_q[T][LANE_OS] < dv_len_q[T][LANE_OS])
    else $error("divider remainder out of range");

  // Lane 3 projection never exceeds one
  a_t_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[ST_INI + T] |-> dv_t_q[T][LANE_OS] <= T_ONE)
    else $error("projection t above one");

  // Zero distance always overlaps
  a_zero_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_o.valid && (result_o.distance_sq == '0) |-> result_o.overlap)
    else $error("zero distance without overlap");

  // Full pipeline with stalled result refuses new queries
  a_full_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (&v_q) && !result_o.ready |-> !query_i.ready)
    else $error("query taken into a full pipeline");

  // Accepted query occupies the input stage next cycle
  a_enter: assert property (@(posedge clk_i) disable iff (!rst_ni)
    query_i.valid && query_i.ready |=> v_q[ST_IN])
    else $error("accepted query lost at input stage");
`endif

endmodule
